[hdl/pbi_pkg.sv]
// pbi_pkg: shared types and constants for the palette builder indexer
// holds config register codes, field widths and the token control struct
// no dependencies
package pbi_pkg;

    // default palette depth
    localparam int PALETTE_DEPTH_DEF = 256;

    // field widths
    localparam int COLOR_W = 32;
    localparam int INDEX_OUT_W = 8;
    localparam int COUNT_OUT_W = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int ALPHA_CLIP_W = 9;
    localparam int BPP_W = 3;
    localparam int MAX_COLORS_W = 9;

    // config register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALPHA_CLIP = 2'd0,
        CFG_BYTES_PER_PIXEL = 2'd1,
        CFG_MAX_COLORS = 2'd2
    } cfg_reg_t;

    // reset values of the config registers
    localparam logic signed [ALPHA_CLIP_W-1:0] ALPHA_CLIP_RST = 9'sd0;
    localparam logic [BPP_W-1:0] BPP_RST = 3'd4;
    localparam logic [MAX_COLORS_W-1:0] MAX_COLORS_RST = 9'd256;

    // pixel size that forces alpha to opaque
    localparam logic [BPP_W-1:0] BPP_RGB = 3'd3;
    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE_MASK = 32'hFF00_0000;

    // control part of a pixel token moving down the cell row
    typedef struct packed {
        logic valid;
        logic sof;
        logic found;
        logic added;
    } tok_ctl_t;

endpackage

[hdl/pbi_cell.sv]
// pbi_cell: one palette slot of the match-and-claim cell row
// holds one entry and its in-use bit, passes the pixel token to the next cell
// depends on pbi_pkg
module pbi_cell
    import pbi_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int CELL_INDEX = 0,
    localparam int IDX_W = $clog2(PALETTE_DEPTH),
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic [MAX_COLORS_W-1:0] max_colors,
    input  tok_ctl_t                ctl_in,
    input  logic [COLOR_W-1:0]      color_in,
    input  logic [IDX_W-1:0]        idx_in,
    input  logic [CNT_W-1:0]        cnt_in,
    output tok_ctl_t                ctl_out,
    output logic [COLOR_W-1:0]      color_out,
    output logic [IDX_W-1:0]        idx_out,
    output logic [CNT_W-1:0]        cnt_out
);

    localparam int LIM_W = (CNT_W > MAX_COLORS_W) ? CNT_W : MAX_COLORS_W;
    localparam logic [LIM_W-1:0] CELL_POS = LIM_W'(CELL_INDEX);
    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(CELL_INDEX);

    logic [COLOR_W-1:0] entry_reg;
    logic               in_use_reg;
    logic               in_use_next;
    tok_ctl_t           ctl_reg;
    tok_ctl_t           ctl_next;
    logic [COLOR_W-1:0] color_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               use_eff;
    logic               room;
    logic               hit;
    logic               claim;

    // slot state as the token sees it, start of image retires the slot
    assign use_eff = in_use_reg && !ctl_in.sof;
    assign room = CELL_POS < LIM_W'(max_colors);
    assign hit = ctl_in.valid && !ctl_in.found && use_eff && (entry_reg == color_in);
    assign claim = ctl_in.valid && !ctl_in.found && !use_eff && room;

    // next slot state and updated token
    always_comb
    begin
        in_use_next = in_use_reg;
        if (ctl_in.valid)
        begin
            in_use_next = use_eff || claim;
        end
        ctl_next = ctl_in;
        ctl_next.found = ctl_in.found || hit || claim;
        ctl_next.added = ctl_in.added || claim;
        idx_next = (hit || claim) ? CELL_IDX : idx_in;
        cnt_next = (use_eff || claim) ? cnt_in + CNT_W'(1) : cnt_in;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= 1'b0;
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            in_use_reg <= in_use_next;
            ctl_reg <= ctl_next;
        end
    end

    // entry and token payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (claim)
            begin
                entry_reg <= color_in;
            end
            color_reg <= color_in;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign color_out = color_reg;
    assign idx_out = idx_reg;
    assign cnt_out = cnt_reg;

endmodule

[hdl/palette_builder_indexer_unit.sv]
// palette_builder_indexer_unit: pipelined palette lookup from pixel to result word
// throughput one pixel per cycle; each pixel walks a row of PALETTE_DEPTH slot cells,
// one cell after another, and then passes through the output register
// the whole row holds while a finished word waits on out_stall
// reset: palette empty, overflow clear, alpha_clip 0, bytes_per_pixel 4, max_colors 256
module palette_builder_indexer_unit
    import pbi_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    localparam int IDX_W = $clog2(PALETTE_DEPTH),
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COLOR_W-1:0]     pixel_color,
    input  logic                   start_of_image,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [INDEX_OUT_W-1:0] palette_index,
    output logic                   new_color,
    output logic                   overflow,
    output logic [COUNT_OUT_W-1:0] colors_used,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic signed [ALPHA_CLIP_W-1:0] alpha_clip_reg;
    logic [BPP_W-1:0]               bpp_reg;
    logic [MAX_COLORS_W-1:0]        max_colors_reg;

    logic                   advance;
    logic [COLOR_W-1:0]     color_fix;
    logic [COLOR_W-1:0]     color_clip;
    logic signed [8:0]      alpha_ext;

    tok_ctl_t               ctl_chain [0:PALETTE_DEPTH];
    logic [COLOR_W-1:0]     color_chain [0:PALETTE_DEPTH];
    logic [IDX_W-1:0]       idx_chain [0:PALETTE_DEPTH];
    logic [CNT_W-1:0]       cnt_chain [0:PALETTE_DEPTH];

    logic                   out_valid_reg;
    logic [INDEX_OUT_W-1:0] index_reg;
    logic                   new_color_reg;
    logic [COUNT_OUT_W-1:0] count_reg;
    logic                   overflow_seen_reg;
    logic                   overflow_seen_next;
    tok_ctl_t               last_ctl;

    // config write port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_clip_reg <= ALPHA_CLIP_RST;
            bpp_reg <= BPP_RST;
            max_colors_reg <= MAX_COLORS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ALPHA_CLIP:      alpha_clip_reg <= $signed(cfg_data[ALPHA_CLIP_W-1:0]);
                CFG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[BPP_W-1:0];
                CFG_MAX_COLORS:      max_colors_reg <= cfg_data[MAX_COLORS_W-1:0];
                default:             ;
            endcase
        end
    end

    // whole row moves unless a finished word is held
    assign advance = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // alpha forcing and clipping ahead of the row
    always_comb
    begin
        color_fix = pixel_color;
        if (bpp_reg == BPP_RGB)
        begin
            color_fix = pixel_color | ALPHA_OPAQUE_MASK;
        end
        alpha_ext = $signed({1'b0, color_fix[31:24]});
        color_clip = (alpha_ext <= alpha_clip_reg) ? '0 : color_fix;
    end

    // token entering the first cell
    always_comb
    begin
        ctl_chain[0].valid = in_valid;
        ctl_chain[0].sof = start_of_image;
        ctl_chain[0].found = 1'b0;
        ctl_chain[0].added = 1'b0;
    end
    assign color_chain[0] = color_clip;
    assign idx_chain[0] = '0;
    assign cnt_chain[0] = '0;

    // row of palette slot cells
    for (genvar k = 0; k < PALETTE_DEPTH; k++)
    begin : g_cell
        pbi_cell #(
            .PALETTE_DEPTH(PALETTE_DEPTH),
            .CELL_INDEX(k)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .advance(advance),
            .max_colors(max_colors_reg),
            .ctl_in(ctl_chain[k]),
            .color_in(color_chain[k]),
            .idx_in(idx_chain[k]),
            .cnt_in(cnt_chain[k]),
            .ctl_out(ctl_chain[k+1]),
            .color_out(color_chain[k+1]),
            .idx_out(idx_chain[k+1]),
            .cnt_out(cnt_chain[k+1])
        );
    end

    // sticky overflow, in token order at the row's end
    assign last_ctl = ctl_chain[PALETTE_DEPTH];

    always_comb
    begin
        overflow_seen_next = overflow_seen_reg;
        if (last_ctl.valid)
        begin
            overflow_seen_next = (overflow_seen_reg && !last_ctl.sof) || !last_ctl.found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            overflow_seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= last_ctl.valid;
            overflow_seen_reg <= overflow_seen_next;
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            index_reg <= INDEX_OUT_W'(idx_chain[PALETTE_DEPTH]);
            new_color_reg <= last_ctl.added;
            count_reg <= COUNT_OUT_W'(cnt_chain[PALETTE_DEPTH]);
        end
    end

    assign out_valid = out_valid_reg;
    assign palette_index = index_reg;
    assign new_color = new_color_reg;
    assign overflow = overflow_seen_reg;
    assign colors_used = count_reg;

`ifndef NO_ASSERTIONS
    // a stalled result word holds steady
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable({palette_index, new_color, overflow, colors_used}))
    else $error("stalled result word changed");

    // a new entry lands at the last counted slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_color |-> palette_index == INDEX_OUT_W'(colors_used - 9'd1))
    else $error("new color index does not match color count");

    // a new entry never comes with a fresh overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_ctl.valid && last_ctl.added |=>
            overflow == $past(overflow_seen_reg && !last_ctl.sof))
    else $error("overflow changed on a word that added a color");
`endif

endmodule

[tb/testbench.sv]
// testbench: drives the palette builder indexer with pixel words and checks each result word
// against an in-house palette tracker; needs pbi_pkg and palette_builder_indexer_unit
module testbench;
    import pbi_pkg::*;

    localparam int RAND_PHASES = 6;
    localparam int PHASE_PIXELS = 225;
    localparam int POOL_MAX = 320;
    localparam int LONG_HOLD = 600;
    localparam int TIMEOUT_CYCLES = 200000;

    // one expected result word
    typedef struct packed {
        logic [INDEX_OUT_W-1:0] index;
        logic                   added;
        logic                   ovf;
        logic [COUNT_OUT_W-1:0] used;
    } pixel_word_t;

    // tracks the palette and the words it predicts
    class palette_tracker;
        logic [COLOR_W-1:0]             entries [PALETTE_DEPTH_DEF];
        int unsigned                    count;
        logic                           ovf_seen;
        logic signed [ALPHA_CLIP_W-1:0] clip_level;
        logic [BPP_W-1:0]               pixel_bytes;
        logic [MAX_COLORS_W-1:0]        color_cap;
        pixel_word_t                    expected_words [$];
        int                             errors;

        function new();
            count = 0;
            ovf_seen = 1'b0;
            clip_level = ALPHA_CLIP_RST;
            pixel_bytes = BPP_RST;
            color_cap = MAX_COLORS_RST;
            errors = 0;
            foreach (entries[i])
                entries[i] = '0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] data);
            case (which)
                CFG_ALPHA_CLIP:      clip_level = data;
                CFG_BYTES_PER_PIXEL: pixel_bytes = data[BPP_W-1:0];
                CFG_MAX_COLORS:      color_cap = data;
                default: ;
            endcase
        endfunction

        // search, append or overflow for one accepted pixel
        function void note_pixel(logic [COLOR_W-1:0] pixel, logic sof);
            logic [COLOR_W-1:0] color;
            int unsigned        limit;
            int unsigned        idx;
            int unsigned        i;
            bit                 hit;
            pixel_word_t        w;
            color = pixel;
            if (sof)
            begin
                count = 0;
                ovf_seen = 1'b0;
            end
            if (pixel_bytes == BPP_RGB)
                color = color | ALPHA_OPAQUE_MASK;
            if (int'(color[31:24]) <= int'(clip_level))
                color = '0;
            // limit saturates at the palette depth
            limit = (color_cap > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : color_cap;
            hit = 1'b0;
            idx = 0;
            for (i = 0; i < count && !hit; i++)
            begin
                if (entries[i] == color)
                begin
                    idx = i;
                    hit = 1'b1;
                end
            end
            w.added = 1'b0;
            if (!hit)
            begin
                if (count < limit)
                begin
                    entries[count] = color;
                    idx = count;
                    count++;
                    w.added = 1'b1;
                end
                else
                begin
                    ovf_seen = 1'b1;
                    idx = 0;
                end
            end
            w.index = idx[INDEX_OUT_W-1:0];
            w.ovf = ovf_seen;
            w.used = count[COUNT_OUT_W-1:0];
            expected_words.push_back(w);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        // compare one result word with the oldest prediction
        task check_word(logic [INDEX_OUT_W-1:0] index, logic added, logic ovf,
                        logic [COUNT_OUT_W-1:0] used);
            pixel_word_t w;
            if (expected_words.size() == 0)
            begin
                report("result word with no pixel pending", index, 0);
                return;
            end
            w = expected_words.pop_front();
            if (index !== w.index)
                report("palette_index", index, w.index);
            if (added !== w.added)
                report("new_color", added, w.added);
            if (ovf !== w.ovf)
                report("overflow", ovf, w.ovf);
            if (used !== w.used)
                report("colors_used", used, w.used);
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [COLOR_W-1:0]     pixel_color;
    logic                   start_of_image;
    logic                   out_valid;
    logic                   out_stall;
    logic [INDEX_OUT_W-1:0] palette_index;
    logic                   new_color;
    logic                   overflow;
    logic [COUNT_OUT_W-1:0] colors_used;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    palette_tracker tracker;
    bit             idling_on;
    bit             long_hold_req;

    palette_builder_indexer_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel_color    (pixel_color),
        .start_of_image (start_of_image),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .palette_index  (palette_index),
        .new_color      (new_color),
        .overflow       (overflow),
        .colors_used    (colors_used),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: check result words and drive out_stall
    initial
    begin : rx_proc
        int gap_left;
        int hold_left;
        gap_left = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                tracker.check_word(palette_index, new_color, overflow, colors_used);
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                out_stall <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // offer one pixel word, with an optional idle burst first
    task automatic send_pixel(input logic [COLOR_W-1:0] color, input logic sof);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap)
            begin
                pixel_color <= $urandom;
                start_of_image <= 1'($urandom_range(0, 1));
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        pixel_color <= color;
        start_of_image <= sof;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_pixel(color, sof);
    endtask

    // stop sending and wait until every predicted word has come back
    task automatic drain_results(input int tail);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // write all three registers while the block is idle
    task automatic set_config(input logic [CFG_DATA_W-1:0] clip,
                              input logic [CFG_DATA_W-1:0] bpp,
                              input logic [CFG_DATA_W-1:0] maxc);
        logic [CFG_DATA_W-1:0] vals [3];
        cfg_reg_t              regs [3];
        int                    k;
        vals = '{clip, bpp, maxc};
        regs = '{CFG_ALPHA_CLIP, CFG_BYTES_PER_PIXEL, CFG_MAX_COLORS};
        drain_results(8);
        for (k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            tracker.write_reg(regs[k], vals[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin : stim_proc
        logic [COLOR_W-1:0]    pool [POOL_MAX];
        logic [COLOR_W-1:0]    color;
        logic [CFG_DATA_W-1:0] clip;
        logic [CFG_DATA_W-1:0] bpp;
        logic [CFG_DATA_W-1:0] maxc;
        logic                  sof;
        int                    ph;
        int                    sent;
        int                    pool_size;
        int                    img_len;
        int                    p;
        int                    k;

        tracker = new();
        idling_on = 1'b1;
        long_hold_req = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        pixel_color <= '0;
        start_of_image <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ALPHA_CLIP;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: clip at alpha 0, hits and appends
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'h00FF_FFFF, 1'b0);
        send_pixel(32'h01FF_FFFF, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h01FF_FFFF, 1'b0);
        send_pixel(32'h8012_3456, 1'b0);

        // clip off, three-byte pixels, one color: overflow and hit after overflow
        set_config(9'h1FF, 9'(BPP_RGB), 9'd1);
        send_pixel(32'h00AB_CDEF, 1'b1);
        send_pixel(32'h12AB_CDEF, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFAB_CDEF, 1'b0);
        send_pixel(32'h0000_0000, 1'b1);

        // clip everything, odd pixel size, zero limit
        set_config(9'd255, 9'd7, 9'd0);
        send_pixel(32'hFF00_0001, 1'b1);
        send_pixel(32'h1234_5678, 1'b0);

        // most negative clip, pixel size 0, limit above the depth
        set_config(9'h100, 9'd0, 9'd300);
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);

        // limit of two, then a new image over stale entries
        set_config(9'd254, 9'(BPP_RST), 9'd2);
        send_pixel(32'hFEFF_FFFF, 1'b1);
        send_pixel(32'hFF00_0000, 1'b0);
        send_pixel(32'hFF00_0001, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFF00_0001, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);

        // random images under random settings
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case ($urandom_range(0, 3))
                0:       clip = 9'h1FF;
                1:       clip = '0;
                default: clip = 9'($urandom_range(0, 511));
            endcase
            bpp = $urandom_range(0, 1) ? 9'(BPP_RGB) : 9'(BPP_RST);
            if ($urandom_range(0, 3) == 0)
                bpp = 9'($urandom_range(0, 511));
            case ($urandom_range(0, 3))
                0:       maxc = 9'd256;
                1:       maxc = 9'($urandom_range(1, 256));
                2:       maxc = 9'($urandom_range(1, 8));
                default: maxc = 9'($urandom_range(0, 511));
            endcase
            if (ph == RAND_PHASES - 1)
            begin
                clip = 9'h1FF;
                maxc = 9'd256;
            end
            set_config(clip, bpp, maxc);
            // last phase runs at full rate on both sides
            idling_on = (ph != RAND_PHASES - 1);
            // long receiver hold so the row fills and stalls the input
            if (ph == 0)
                long_hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_PIXELS)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    pool_size = $urandom_range(200, POOL_MAX);
                    img_len = $urandom_range(150, 400);
                end
                else
                begin
                    pool_size = $urandom_range(1, 40);
                    img_len = $urandom_range(4, 80);
                end
                for (k = 0; k < pool_size; k++)
                    pool[k] = $urandom;
                for (p = 0; p < img_len && sent < PHASE_PIXELS; p++)
                begin
                    if ($urandom_range(0, 99) < 88)
                        color = pool[$urandom_range(0, pool_size - 1)];
                    else
                        color = $urandom;
                    // mostly one start flag per image, some missing or stray
                    if (p == 0)
                        sof = ($urandom_range(0, 9) != 0);
                    else
                        sof = ($urandom_range(0, 49) == 0);
                    send_pixel(color, sof);
                    sent++;
                end
            end
        end

        drain_results(PALETTE_DEPTH_DEF + 16);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
